// ===== rtl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants of the HEX record decoder
// Record phases, ASCII codes of the framing characters and the hex digit
// decode used by the decoder core.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // Default image capacity in bytes
  localparam int unsigned MAX_BYTES_DEF = 32'd16777216;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Framing characters
  localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'

  // Record parse phase
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_ADDR = 3'd2,
    PH_TYPE = 3'd3,
    PH_DATA = 3'd4,
    PH_SKIP = 3'd5
  } phase_t;

  // Decode one ASCII hex digit; anything else reads as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end
    return v;
  endfunction

endpackage

// ===== rtl/ihex_char_if.sv =====
// ----------------------------------------------------------------------------
// ihex_char_if: character stream channel
// One ASCII character of the file text per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// ===== rtl/ihex_rslt_if.sv =====
// ----------------------------------------------------------------------------
// ihex_rslt_if: decoded result channel
// Carries one data byte or one end-of-file summary per word.
// ----------------------------------------------------------------------------
interface ihex_rslt_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [23:0] byte_index;
  logic [24:0] total_bytes;
  logic [8:0]  sector_count;
  logic [16:0] page_count;
  logic        overflow;

  modport source (
    output valid, output kind, output data_byte, output byte_index,
    output total_bytes, output sector_count, output page_count,
    output overflow, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input byte_index,
    input total_bytes, input sector_count, input page_count,
    input overflow, output ready
  );
endinterface

// ===== rtl/intel_hex_record_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_decoder_unit: streaming HEX file decoder
// Parses record framing one character at a time and emits data bytes and
// an end-of-file summary.
// ----------------------------------------------------------------------------
// Takes one character per cycle and never stalls on its own: each accepted
// character updates the parse state in the same cycle and, when it completes
// a data byte or an end-of-file record, loads the single result register, so
// a result appears in the cycle after the character that caused it. The input
// is held off only while that result register is full and the sink is not
// taking it. Data records ("00") yield one byte per digit pair with a running
// index; an end-of-file record ("01") yields the byte total with 64 KiB sector
// and 256-byte page counts and restarts the count. Other records, checksums
// and addresses are ignored, non-hex digits read as zero, and bytes beyond
// MAX_BYTES are dropped and reported in the end summary.
module intel_hex_record_decoder_unit #(
  parameter int unsigned MAX_BYTES = ihex_pkg::MAX_BYTES_DEF
) (
  input logic         clk,
  input logic         rst,
  ihex_char_if.sink   chars,
  ihex_rslt_if.source results
);
  import ihex_pkg::*;

  localparam int CntW = $clog2(MAX_BYTES + 1);
  localparam int ExtW = (CntW + 1 > 26) ? CntW + 1 : 26;

  // Parse state
  phase_t           phase, phase_next;
  logic [8:0]       char_counter, char_counter_next;
  logic [7:0]       record_length, record_length_next;
  logic [7:0]       type_first_char, type_first_char_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic [CntW-1:0]  byte_count, byte_count_next;
  logic             overflow_seen, overflow_seen_next;

  // Result register
  logic             res_valid;
  logic             res_kind;
  logic [7:0]       res_byte;
  logic [23:0]      res_index;
  logic [24:0]      res_total;
  logic [8:0]       res_sectors;
  logic [16:0]      res_pages;
  logic             res_ovf;

  logic             accept;
  logic             emit;
  logic             emit_kind;
  logic [3:0]       nib;
  logic [8:0]       cc_inc;
  logic [ExtW-1:0]  cnt_ext;
  logic [ExtW-1:0]  sum_sector;
  logic [ExtW-1:0]  sum_page;

  assign accept = chars.valid && chars.ready;
  assign chars.ready = !res_valid || results.ready;

  assign nib    = hex_nibble(chars.ch);
  assign cc_inc = char_counter + 9'd1;

  // Round the byte total up to sectors and pages
  assign cnt_ext    = ExtW'(byte_count);
  assign sum_sector = cnt_ext + ExtW'(17'h0ffff);
  assign sum_page   = cnt_ext + ExtW'(9'h0ff);

  // Advance the parse state for one character
  always_comb begin
    phase_next           = phase;
    char_counter_next    = char_counter;
    record_length_next   = record_length;
    type_first_char_next = type_first_char;
    high_nibble_next     = high_nibble;
    byte_count_next      = byte_count;
    overflow_seen_next   = overflow_seen;
    emit                 = 1'b0;
    emit_kind            = KIND_DATA;
    case (phase)
      PH_LEN: begin
        if (char_counter == 9'd0) begin
          high_nibble_next  = nib;
          char_counter_next = 9'd1;
        end else begin
          record_length_next = {high_nibble, nib};
          char_counter_next  = 9'd0;
          phase_next         = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (cc_inc >= 9'd4) begin
          char_counter_next = 9'd0;
          phase_next        = PH_TYPE;
        end else begin
          char_counter_next = cc_inc;
        end
      end
      PH_TYPE: begin
        if (char_counter == 9'd0) begin
          type_first_char_next = chars.ch;
          char_counter_next    = 9'd1;
        end else begin
          char_counter_next = 9'd0;
          if (type_first_char == CH_ZERO && chars.ch == CH_ZERO) begin
            phase_next = (record_length == 8'd0) ? PH_SKIP : PH_DATA;
          end else if (type_first_char == CH_ZERO && chars.ch == CH_ONE) begin
            emit               = 1'b1;
            emit_kind          = KIND_END;
            byte_count_next    = '0;
            overflow_seen_next = 1'b0;
            phase_next         = PH_HUNT;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_DATA: begin
        if (!char_counter[0]) begin
          high_nibble_next = nib;
        end else if (byte_count < CntW'(MAX_BYTES)) begin
          emit            = 1'b1;
          emit_kind       = KIND_DATA;
          byte_count_next = byte_count + CntW'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
        if (cc_inc >= {record_length, 1'b0}) begin
          char_counter_next = 9'd0;
          phase_next        = PH_SKIP;
        end else begin
          char_counter_next = cc_inc;
        end
      end
      default: begin
        // Hunt and skip: wait for the next record mark
        if (chars.ch == CH_COLON) begin
          char_counter_next = 9'd0;
          phase_next        = PH_LEN;
        end else begin
          phase_next = (phase == PH_SKIP) ? PH_SKIP : PH_HUNT;
        end
      end
    endcase
  end

  // Hold the parse state between accepted words
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      char_counter    <= '0;
      record_length   <= '0;
      type_first_char <= '0;
      high_nibble     <= '0;
      byte_count      <= '0;
      overflow_seen   <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      char_counter    <= char_counter_next;
      record_length   <= record_length_next;
      type_first_char <= type_first_char_next;
      high_nibble     <= high_nibble_next;
      byte_count      <= byte_count_next;
      overflow_seen   <= overflow_seen_next;
    end
  end

  // Result valid: load on an emitting word, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= emit;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_kind <= emit_kind;
      res_ovf  <= overflow_seen;
      if (emit_kind == KIND_END) begin
        res_byte    <= 8'd0;
        res_index   <= 24'd0;
        res_total   <= 25'(cnt_ext);
        res_sectors <= 9'(sum_sector >> 16);
        res_pages   <= 17'(sum_page >> 8);
      end else begin
        res_byte    <= {high_nibble, nib};
        res_index   <= 24'(byte_count);
        res_total   <= 25'd0;
        res_sectors <= 9'd0;
        res_pages   <= 17'd0;
      end
    end
  end

  assign results.valid        = res_valid;
  assign results.kind         = res_kind;
  assign results.data_byte    = res_byte;
  assign results.byte_index   = res_index;
  assign results.total_bytes  = res_total;
  assign results.sector_count = res_sectors;
  assign results.page_count   = res_pages;
  assign results.overflow     = res_ovf;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CntW'(MAX_BYTES))
    else $error("byte count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> byte_count == CntW'(MAX_BYTES))
    else $error("overflow flagged below capacity");

  a_data_no_ovf: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_DATA |-> !res_ovf && res_total == 25'd0)
    else $error("data word carries summary fields");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && emit && emit_kind == KIND_END |=> byte_count == '0 && !overflow_seen)
    else $error("count not cleared after end of file");

endmodule
